// ===== sv/vgm_command_stream_encoder_core_assert.svh =====
// Assertion macros for the VGM command stream encoder.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef VGM_COMMAND_STREAM_ENCODER_CORE_ASSERT_SVH
`define VGM_COMMAND_STREAM_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VGMCSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VGMCSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vgmcse_pkg.sv =====
// Shared types and constants for the VGM command stream encoder.
// No dependencies; used by the controller, datapath and top level.
package vgmcse_pkg;

	// Default width of the pending wait accumulator.
	localparam int PENDING_WAIT_BITS_DEF = 20;

	// Item modes.
	localparam logic [1:0] MODE_WAIT = 2'd0;
	localparam logic [1:0] MODE_AY   = 2'd1;
	localparam logic [1:0] MODE_YM   = 2'd2;
	localparam logic [1:0] MODE_END  = 2'd3;

	// Command bytes and wait constants.
	localparam logic [7:0]  CMD_WAIT_NTSC  = 8'h62;
	localparam logic [7:0]  CMD_WAIT_PAL   = 8'h63;
	localparam logic [7:0]  CMD_WAIT_SHORT = 8'h70;
	localparam logic [7:0]  CMD_WAIT_LONG  = 8'h61;
	localparam logic [7:0]  CMD_AY_WRITE   = 8'hA0;
	localparam logic [7:0]  CMD_YM_WRITE   = 8'h54;
	localparam logic [7:0]  BYTE_FULL      = 8'hFF;
	localparam int          WAIT_NTSC      = 735;
	localparam int          WAIT_PAL       = 882;
	localparam int          WAIT_SHORT_MAX = 16;
	localparam int          WAIT_CHUNK     = 65535;

	// Input item.
	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] wait_samples;
		logic [7:0]  reg_addr;
		logic [7:0]  reg_data;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last_of_run;
		logic [31:0] stream_bytes;
		logic [31:0] samples_total;
	} result_t;

	// Which byte the datapath places in the output register.
	typedef enum logic [2:0] {
		SEL_SHORT,
		SEL_LONG_CMD,
		SEL_LONG_LO,
		SEL_LONG_HI,
		SEL_CHIP_CMD,
		SEL_CHIP_ADDR,
		SEL_CHIP_DATA
	} sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic emit;
		sel_t sel;
		logic last;
		logic chunk_step;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_wait;
		logic in_is_write;
		logic pend_zero;
		logic pend_short;
		logic work_big;
		logic item_is_write;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== sv/vgmcse_dp.sv =====
// Datapath of the VGM command stream encoder: wait accumulator, counters,
// flush work register and the output register. Depends on vgmcse_pkg.
module vgmcse_dp #(
	parameter int PENDING_WAIT_BITS = vgmcse_pkg::PENDING_WAIT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vgmcse_pkg::item_t     item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output vgmcse_pkg::result_t   result,
	input  vgmcse_pkg::ctrl_cmd_t cmd,
	output vgmcse_pkg::dp_sts_t   sts
);

	localparam int P = PENDING_WAIT_BITS;

	logic [P-1:0]  pending_q;
	logic [P-1:0]  work_q;
	logic [1:0]    mode_q;
	logic [7:0]    addr_q;
	logic [7:0]    data_q;
	logic [31:0]   sample_count_q;
	logic [31:0]   byte_count_q;
	logic          out_valid_q;
	vgmcse_pkg::result_t out_q;

	logic [P:0]    sum;
	logic [P-1:0]  pend_next;
	logic [P-1:0]  work_dec;
	logic [7:0]    byte_mux;
	logic [31:0]   byte_count_inc;

	// Saturating add of the new wait to the pending wait.
	assign sum       = {1'b0, pending_q} + (P+1)'(item.wait_samples);
	assign pend_next = sum[P] ? {P{1'b1}} : sum[P-1:0];
	assign work_dec  = work_q - P'(1);
	assign byte_count_inc = byte_count_q + 32'd1;

	// Status for the controller.
	always_comb begin
		sts.in_is_wait    = (item.mode == vgmcse_pkg::MODE_WAIT);
		sts.in_is_write   = (item.mode == vgmcse_pkg::MODE_AY) ||
			(item.mode == vgmcse_pkg::MODE_YM);
		sts.pend_zero     = (pending_q == '0);
		sts.pend_short    = (pending_q == P'(vgmcse_pkg::WAIT_NTSC)) ||
			(pending_q == P'(vgmcse_pkg::WAIT_PAL)) ||
			(pending_q <= P'(vgmcse_pkg::WAIT_SHORT_MAX));
		sts.work_big      = (work_q > P'(vgmcse_pkg::WAIT_CHUNK));
		sts.item_is_write = (mode_q == vgmcse_pkg::MODE_AY) ||
			(mode_q == vgmcse_pkg::MODE_YM);
		sts.out_free      = !out_valid_q || !result_stall;
	end

	// Byte selection for the next beat.
	always_comb begin
		case (cmd.sel)
			vgmcse_pkg::SEL_SHORT: begin
				if (work_q == P'(vgmcse_pkg::WAIT_NTSC)) begin
					byte_mux = vgmcse_pkg::CMD_WAIT_NTSC;
				end else if (work_q == P'(vgmcse_pkg::WAIT_PAL)) begin
					byte_mux = vgmcse_pkg::CMD_WAIT_PAL;
				end else begin
					byte_mux = vgmcse_pkg::CMD_WAIT_SHORT | {4'd0, work_dec[3:0]};
				end
			end
			vgmcse_pkg::SEL_LONG_CMD: byte_mux = vgmcse_pkg::CMD_WAIT_LONG;
			vgmcse_pkg::SEL_LONG_LO:
				byte_mux = sts.work_big ? vgmcse_pkg::BYTE_FULL : work_q[7:0];
			vgmcse_pkg::SEL_LONG_HI:
				byte_mux = sts.work_big ? vgmcse_pkg::BYTE_FULL : work_q[15:8];
			vgmcse_pkg::SEL_CHIP_CMD:
				byte_mux = (mode_q == vgmcse_pkg::MODE_AY) ?
					vgmcse_pkg::CMD_AY_WRITE : vgmcse_pkg::CMD_YM_WRITE;
			vgmcse_pkg::SEL_CHIP_ADDR: byte_mux = addr_q;
			vgmcse_pkg::SEL_CHIP_DATA: byte_mux = data_q;
			default: byte_mux = data_q;
		endcase
	end

	// Control registers: pending wait, counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= '0;
			sample_count_q <= '0;
			byte_count_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (sts.in_is_wait) begin
					pending_q      <= pend_next;
					sample_count_q <= sample_count_q + 32'(item.wait_samples);
				end else begin
					pending_q <= '0;
				end
			end
			if (cmd.emit) begin
				byte_count_q <= byte_count_inc;
				out_valid_q  <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: latched item, flush work value and output beat.
	always_ff @(posedge clk) begin
		if (cmd.accept && !sts.in_is_wait) begin
			work_q <= pending_q;
			mode_q <= item.mode;
			addr_q <= item.reg_addr;
			data_q <= item.reg_data;
		end else if (cmd.chunk_step) begin
			work_q <= work_q - P'(vgmcse_pkg::WAIT_CHUNK);
		end
		if (cmd.emit) begin
			out_q.out_byte      <= byte_mux;
			out_q.last_of_run   <= cmd.last;
			out_q.stream_bytes  <= byte_count_inc;
			out_q.samples_total <= sample_count_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== sv/vgmcse_ctrl.sv =====
// Controller state machine of the VGM command stream encoder: sequences the
// wait flush and chip write bytes. Depends on vgmcse_pkg.
module vgmcse_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  vgmcse_pkg::dp_sts_t   sts,
	output vgmcse_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHORT,
		ST_LONG_CMD,
		ST_LONG_LO,
		ST_LONG_HI,
		ST_CHIP_CMD,
		ST_CHIP_ADDR,
		ST_CHIP_DATA
	} state_t;

	state_t state_q;
	state_t state_next;

	assign item_stall = (state_q != ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_next     = state_q;
		cmd.accept     = 1'b0;
		cmd.emit       = 1'b0;
		cmd.sel        = vgmcse_pkg::SEL_SHORT;
		cmd.last       = 1'b0;
		cmd.chunk_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (!sts.in_is_wait) begin
						if (!sts.pend_zero) begin
							state_next = sts.pend_short ? ST_SHORT : ST_LONG_CMD;
						end else if (sts.in_is_write) begin
							state_next = ST_CHIP_CMD;
						end
					end
				end
			end
			ST_SHORT: begin
				cmd.sel = vgmcse_pkg::SEL_SHORT;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.last   = !sts.item_is_write;
					state_next = sts.item_is_write ? ST_CHIP_CMD : ST_IDLE;
				end
			end
			ST_LONG_CMD: begin
				cmd.sel = vgmcse_pkg::SEL_LONG_CMD;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					state_next = ST_LONG_LO;
				end
			end
			ST_LONG_LO: begin
				cmd.sel = vgmcse_pkg::SEL_LONG_LO;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					state_next = ST_LONG_HI;
				end
			end
			ST_LONG_HI: begin
				cmd.sel = vgmcse_pkg::SEL_LONG_HI;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.work_big) begin
						cmd.chunk_step = 1'b1;
						state_next     = ST_LONG_CMD;
					end else begin
						cmd.last   = !sts.item_is_write;
						state_next = sts.item_is_write ? ST_CHIP_CMD : ST_IDLE;
					end
				end
			end
			ST_CHIP_CMD: begin
				cmd.sel = vgmcse_pkg::SEL_CHIP_CMD;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					state_next = ST_CHIP_ADDR;
				end
			end
			ST_CHIP_ADDR: begin
				cmd.sel = vgmcse_pkg::SEL_CHIP_ADDR;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					state_next = ST_CHIP_DATA;
				end
			end
			ST_CHIP_DATA: begin
				cmd.sel = vgmcse_pkg::SEL_CHIP_DATA;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.last   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== sv/vgm_command_stream_encoder_core.sv =====
// VGM command stream encoder, top level: controller plus datapath.
// A wait item is accepted and added to the pending wait. A write or end item is accepted,
// then its bytes are emitted (0, 1 or 3 per chunk of flush, 3 for a write).
// The first beat of an item passes the state register and then the output register
// before it is valid, and a stalled output holds the controller on its current byte.
// Asynchronous active-low reset clears the pending wait and both counters.
module vgm_command_stream_encoder_core #(
	parameter int PENDING_WAIT_BITS = vgmcse_pkg::PENDING_WAIT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  vgmcse_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output vgmcse_pkg::result_t result
);

`include "vgm_command_stream_encoder_core_assert.svh"

	vgmcse_pkg::ctrl_cmd_t cmd;
	vgmcse_pkg::dp_sts_t   sts;

	// Sequencer.
	vgmcse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Accumulators, counters and output register.
	vgmcse_dp #(
		.PENDING_WAIT_BITS (PENDING_WAIT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cmd          (cmd),
		.sts          (sts)
	);

	// A beat is loaded only when the output register can take it.
	`VGMCSE_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "beat loaded into a full output")
	// An item is never taken while a byte is being emitted.
	`VGMCSE_ASSERT_NOW(a_accept_quiet, item_valid && !item_stall, !cmd.emit,
		"item accepted during emission")
	// Every loaded beat shows up valid with the byte count advanced by one.
	`VGMCSE_ASSERT_NEXT(a_emit_count, cmd.emit,
		result_valid && (result.stream_bytes == $past(result.stream_bytes) + 32'd1) ||
		result_valid && $past(!result_valid),
		"emitted beat has wrong byte count")

endmodule
